### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is low.
`define PKSWL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define PKSWL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### design/pkswl_pkg.sv
package pkswl_pkg;

    localparam int FLOWS_DEF   = 64;
    localparam int HISTORY_DEF = 8;

    localparam logic [3:0]  ATTEMPT_LIMIT_RST = 4'd5;
    localparam logic [30:0] WINDOW_TICKS_RST  = 31'd60;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_RECORD = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [0:0] {
        REG_ATTEMPT_LIMIT = 1'b0,
        REG_WINDOW_TICKS  = 1'b1
    } t_reg;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPEND,
        S_COUNT,
        S_STALE_RD,
        S_STALE_WT,
        S_DONE
    } t_state;

endpackage

### design/per_key_sliding_window_limiter_core.sv
// Per-key sliding-window limiter. A request (check, record or clear) is taken when start is
// high and busy is low; exactly one result beat follows on o_result_valid, one cycle wide,
// and must be taken then since the receiver cannot stall. After reset the block clears its
// entry table with busy high; configuration writes are taken during that pass. Each check,
// record or clear scans the entry memory one entry per cycle, then decides; a check of a
// known key or a record then reads the stored stamps of its entry one per cycle through the
// stamp memory read port. A record, new key or known, first writes its stamp in an append
// step, with fill counted after the append. A check of an unknown key or a clear puts its
// result beat out after the decision step, with no stamp read. Busy drops in the cycle
// after the result beat. A record for a new key when no entry is free also walks the
// entries and their stamps in order to find a stale one, with no recent stamp, and is
// dropped if none is found. An unused operation code puts its result beat out in the cycle
// after acceptance.
`include "assert_macros.svh"

module per_key_sliding_window_limiter_core #(
    parameter int FLOWS   = pkswl_pkg::FLOWS_DEF,
    parameter int HISTORY = pkswl_pkg::HISTORY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_flow_key,
    input  logic [31:0] i_time_now,
    output logic        o_result_valid,
    output logic        o_limited,
    output logic [3:0]  o_recent_count,
    output logic        o_dropped
);

    localparam int IDX_W  = $clog2(FLOWS);
    localparam int HEAD_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int FILL_W = $clog2(HISTORY + 1);
    localparam int CW     = FILL_W + 1;
    localparam int XW     = (CW > 5) ? CW : 5;
    localparam int SDEPTH = FLOWS * HISTORY;
    localparam int SA_W   = $clog2(SDEPTH);
    localparam int EW     = 1 + FILL_W + HEAD_W + 32;
    localparam int HEAD_LO = 32;
    localparam int FILL_LO = 32 + HEAD_W;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(FLOWS - 1);
    localparam logic [SA_W-1:0]   HIST_SA   = SA_W'(HISTORY);
    localparam logic [FILL_W-1:0] HIST_FILL = FILL_W'(HISTORY);
    localparam logic [HEAD_W-1:0] LAST_HEAD = HEAD_W'(HISTORY - 1);

    pkswl_pkg::t_state r_state, n_state;

    logic [3:0]  r_max;
    logic [30:0] r_win;

    logic [1:0]        r_op, n_op;
    logic [31:0]       r_key, n_key;
    logic [31:0]       r_now, n_now;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_last, n_last;
    logic              r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic [FILL_W-1:0] r_hit_fill, n_hit_fill;
    logic [HEAD_W-1:0] r_hit_head, n_hit_head;
    logic              r_free, n_free;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [IDX_W-1:0]  r_e, n_e;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [HEAD_W-1:0] r_head, n_head;
    logic [HEAD_W-1:0] r_k, n_k;
    logic [FILL_W-1:0] r_cnt, n_cnt;
    logic              r_stale, n_stale;
    logic              r_res_lim, n_res_lim;
    logic [3:0]        r_res_cnt, n_res_cnt;
    logic              r_res_drop, n_res_drop;

    logic              e_we;
    logic [IDX_W-1:0]  e_waddr;
    logic [EW-1:0]     e_wdata;
    logic [EW-1:0]     e_rdata;
    logic              s_we;
    logic [SA_W-1:0]   s_waddr;
    logic [SA_W-1:0]   s_raddr;
    logic [31:0]       s_rdata;

    logic              e_valid;
    logic [FILL_W-1:0] e_fill;
    logic [HEAD_W-1:0] e_head;
    logic [31:0]       e_key;
    logic [SA_W-1:0]   base;
    logic [31:0]       age;
    logic              recent;
    logic [FILL_W-1:0] fill_nx;
    logic [HEAD_W-1:0] head_nx;
    logic [XW-1:0]     cnt_x;
    logic [3:0]        cnt_clip;
    logic              cfg_we;
    logic              in_count;
    logic              res_clean;

    pkswl_ram #(
        .WIDTH (EW),
        .DEPTH (FLOWS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (r_idx),
        .o_rdata (e_rdata)
    );

    pkswl_ram #(
        .WIDTH (32),
        .DEPTH (SDEPTH)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (r_now),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= pkswl_pkg::ATTEMPT_LIMIT_RST;
            r_win <= pkswl_pkg::WINDOW_TICKS_RST;
        end else if (cfg_we) begin
            unique case (paddr[2])
                pkswl_pkg::REG_ATTEMPT_LIMIT: r_max <= pwdata[3:0];
                pkswl_pkg::REG_WINDOW_TICKS:  r_win <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pkswl_pkg::REG_ATTEMPT_LIMIT: prdata = {28'd0, r_max};
            pkswl_pkg::REG_WINDOW_TICKS:  prdata = {1'b0, r_win};
            default:                      prdata = '0;
        endcase
    end

    // Datapath helpers
    assign e_valid = e_rdata[EW-1];
    assign e_fill  = e_rdata[FILL_LO +: FILL_W];
    assign e_head  = e_rdata[HEAD_LO +: HEAD_W];
    assign e_key   = e_rdata[31:0];

    assign base    = SA_W'(r_e) * HIST_SA;
    assign s_raddr = base + SA_W'(r_k);
    assign s_waddr = base + SA_W'(r_head);

    assign age     = r_now - s_rdata;
    assign recent  = (age <= {1'b0, r_win});

    assign fill_nx = (r_fill < HIST_FILL) ? r_fill + FILL_W'(1) : r_fill;
    assign head_nx = (r_head == LAST_HEAD) ? '0 : r_head + HEAD_W'(1);

    assign cnt_x    = XW'(r_cnt);
    assign cnt_clip = (cnt_x > XW'(15)) ? 4'd15 : cnt_x[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pkswl_pkg::S_INIT;
            r_idx    <= '0;
            r_last   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_last   <= n_last;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_now      <= n_now;
        r_rd_idx   <= n_rd_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_fill <= n_hit_fill;
        r_hit_head <= n_hit_head;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_e        <= n_e;
        r_fill     <= n_fill;
        r_head     <= n_head;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_stale    <= n_stale;
        r_res_lim  <= n_res_lim;
        r_res_cnt  <= n_res_cnt;
        r_res_drop <= n_res_drop;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_now      = r_now;
        n_idx      = r_idx;
        n_last     = r_last;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_fill = r_hit_fill;
        n_hit_head = r_hit_head;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_e        = r_e;
        n_fill     = r_fill;
        n_head     = r_head;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_stale    = r_stale;
        n_res_lim  = r_res_lim;
        n_res_cnt  = r_res_cnt;
        n_res_drop = r_res_drop;
        e_we       = 1'b0;
        e_waddr    = r_idx;
        e_wdata    = '0;
        s_we       = 1'b0;

        unique case (r_state)
            pkswl_pkg::S_INIT: begin
                // clear one entry a cycle
                e_we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = pkswl_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            pkswl_pkg::S_IDLE: begin
                if (start) begin
                    n_op       = i_operation;
                    n_key      = i_flow_key;
                    n_now      = i_time_now;
                    n_res_lim  = 1'b0;
                    n_res_cnt  = '0;
                    n_res_drop = 1'b0;
                    unique case (i_operation) inside
                        pkswl_pkg::OP_CHECK, pkswl_pkg::OP_RECORD, pkswl_pkg::OP_CLEAR: begin
                            n_idx    = '0;
                            n_last   = 1'b0;
                            n_rd_vld = 1'b0;
                            n_hit    = 1'b0;
                            n_free   = 1'b0;
                            n_state  = pkswl_pkg::S_SCAN;
                        end
                        default: n_state = pkswl_pkg::S_DONE;
                    endcase
                end
            end

            pkswl_pkg::S_SCAN: begin
                if (!r_last) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_last = 1'b1;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    if (e_valid && (e_key == r_key) && !r_hit) begin
                        n_hit      = 1'b1;
                        n_hit_idx  = r_rd_idx;
                        n_hit_fill = e_fill;
                        n_hit_head = e_head;
                    end
                    if (!e_valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_rd_idx;
                    end
                end
                if (r_last && !r_rd_vld) begin
                    n_state = pkswl_pkg::S_DECIDE;
                end
            end

            pkswl_pkg::S_DECIDE: begin
                unique case (r_op)
                    pkswl_pkg::OP_CHECK: begin
                        if (r_hit) begin
                            n_e      = r_hit_idx;
                            n_fill   = r_hit_fill;
                            n_stale  = 1'b0;
                            n_k      = '0;
                            n_rd_vld = 1'b0;
                            n_cnt    = '0;
                            n_last   = (r_hit_fill == '0);
                            n_state  = pkswl_pkg::S_COUNT;
                        end else begin
                            n_res_lim = (r_max == 4'd0);
                            n_state   = pkswl_pkg::S_DONE;
                        end
                    end
                    pkswl_pkg::OP_RECORD: begin
                        if (r_hit) begin
                            n_e     = r_hit_idx;
                            n_fill  = r_hit_fill;
                            n_head  = r_hit_head;
                            n_state = pkswl_pkg::S_APPEND;
                        end else if (r_free) begin
                            n_e     = r_free_idx;
                            n_fill  = '0;
                            n_head  = '0;
                            n_state = pkswl_pkg::S_APPEND;
                        end else begin
                            n_idx   = '0;
                            n_state = pkswl_pkg::S_STALE_RD;
                        end
                    end
                    pkswl_pkg::OP_CLEAR: begin
                        if (r_hit) begin
                            e_we    = 1'b1;
                            e_waddr = r_hit_idx;
                        end
                        n_state = pkswl_pkg::S_DONE;
                    end
                    default: n_state = pkswl_pkg::S_DONE;
                endcase
            end

            pkswl_pkg::S_APPEND: begin
                s_we     = 1'b1;
                e_we     = 1'b1;
                e_waddr  = r_e;
                e_wdata  = {1'b1, fill_nx, head_nx, r_key};
                n_fill   = fill_nx;
                n_head   = head_nx;
                n_stale  = 1'b0;
                n_k      = '0;
                n_rd_vld = 1'b0;
                n_cnt    = '0;
                n_last   = 1'b0;
                n_state  = pkswl_pkg::S_COUNT;
            end

            pkswl_pkg::S_COUNT: begin
                if (!r_last) begin
                    n_rd_vld = 1'b1;
                    n_k      = r_k + HEAD_W'(1);
                    if ((CW'(r_k) + CW'(1)) == CW'(r_fill)) begin
                        n_last = 1'b1;
                    end
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld && recent) begin
                    n_cnt = r_cnt + FILL_W'(1);
                end
                if (r_last && !r_rd_vld) begin
                    if (!r_stale) begin
                        n_res_cnt = cnt_clip;
                        n_res_lim = (r_op == pkswl_pkg::OP_CHECK) && (cnt_clip >= r_max);
                        n_state   = pkswl_pkg::S_DONE;
                    end else if (r_cnt == '0) begin
                        // take this stale entry over
                        n_fill  = '0;
                        n_head  = '0;
                        n_state = pkswl_pkg::S_APPEND;
                    end else if (r_idx == LAST_IDX) begin
                        n_res_drop = 1'b1;
                        n_state    = pkswl_pkg::S_DONE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = pkswl_pkg::S_STALE_RD;
                    end
                end
            end

            pkswl_pkg::S_STALE_RD: begin
                n_state = pkswl_pkg::S_STALE_WT;
            end

            pkswl_pkg::S_STALE_WT: begin
                n_e      = r_idx;
                n_fill   = e_fill;
                n_stale  = 1'b1;
                n_k      = '0;
                n_rd_vld = 1'b0;
                n_cnt    = '0;
                n_last   = (e_fill == '0);
                n_state  = pkswl_pkg::S_COUNT;
            end

            pkswl_pkg::S_DONE: begin
                n_state = pkswl_pkg::S_IDLE;
            end

            default: n_state = pkswl_pkg::S_IDLE;
        endcase
    end

    assign busy           = (r_state != pkswl_pkg::S_IDLE);
    assign o_result_valid = (r_state == pkswl_pkg::S_DONE);
    assign o_limited      = r_res_lim;
    assign o_recent_count = r_res_cnt;
    assign o_dropped      = r_res_drop;

    assign in_count  = (r_state == pkswl_pkg::S_COUNT);
    assign res_clean = !(o_dropped && (o_limited || (o_recent_count != 4'd0)));

    `PKSWL_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy, "busy not raised on accept")
    `PKSWL_ASSERT(a_result_then_idle, o_result_valid |=> !busy, "busy after result beat")
    `PKSWL_ASSERT(a_fill_bound, in_count |-> (r_fill <= HIST_FILL), "fill over history depth")
    `PKSWL_ASSERT_ALWAYS(a_drop_fields, o_result_valid |-> res_clean, "drop with nonzero fields")

endmodule

### design/pkswl_ram.sv
module pkswl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
